// File: sv/nrt_pkg.sv
// nrt_pkg: command codes and transaction types for the name route table
// used by nrt_front, nrt_fifo, nrt_back and name_route_table
`default_nettype none
package nrt_pkg;

  typedef enum logic [2:0] {
    CMD_LOOKUP  = 3'd0,
    CMD_INVAL   = 3'd1,
    CMD_ROUTE   = 3'd2,
    CMD_ANY     = 3'd3,
    CMD_CHANGED = 3'd4
  } cmd_t;

  // classified command carried from the front to the back
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] name;
    logic        peer_given;
    logic [2:0]  peer_link;
    logic [5:0]  entry_sel;
  } nrt_item_t;

endpackage
`default_nettype wire

// File: sv/name_route_table.sv
// name_route_table: top level joining front, queue and back
// depends on nrt_pkg, nrt_front, nrt_fifo, nrt_back
//
// A command transaction is taken when start is high and busy is low. Each
// command yields one result, shown on the result ports for one cycle with
// done high. The receiver cannot stall.
// A route query, any-route query or changed-flag read passes through the
// finishing state. A lookup reads and compares one entry at a time, in order,
// up to the match; an invalidate walks the used entries, one table entry per
// cycle, writing back each entry while reading the next. One command is in
// flight at a time; busy stays high until the back is idle again.
// Reset: synchronous, leaves entry 0 empty, entry 1 as the broadcast name,
// both with the peripheral route bit, two entries used, changed flag set.
`default_nettype none
module name_route_table #(
  parameter int TABLE_ENTRIES   = 64,
  parameter int PEER_LINKS      = 6,
  parameter int PERIPHERAL_LINK = 0,
  parameter int NAME_BYTES      = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic [63:0] dest_name,
  input  wire logic        peer_given,
  input  wire logic [2:0]  peer_link,
  input  wire logic [5:0]  entry_sel,
  output logic             done,
  output logic [5:0]       entry_index,
  output logic             table_full,
  output logic             answer_bit,
  output logic [6:0]       routeless_count
);
  import nrt_pkg::*;

  nrt_item_t f_item, q_head;
  logic f_valid, q_ne, q_room, b_pop, b_idle, pending;

  // one command in flight from acceptance to its result
  always_ff @(posedge clk) begin
    if (rst) pending <= 1'b0;
    else if (start && !busy) pending <= 1'b1;
    else if (done) pending <= 1'b0;
  end
  assign busy = pending || !q_room || !b_idle;

  nrt_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk, .rst, .start, .can_take(!busy), .cmd, .dest_name, .peer_given,
    .peer_link, .entry_sel, .item(f_item), .item_valid(f_valid)
  );

  nrt_fifo u_fifo (
    .clk, .rst, .push(f_valid), .push_item(f_item), .pop(b_pop),
    .head(q_head), .not_empty(q_ne), .has_room(q_room)
  );

  nrt_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .PEER_LINKS(PEER_LINKS),
    .PERIPHERAL_LINK(PERIPHERAL_LINK), .NAME_BYTES(NAME_BYTES)
  ) u_back (
    .clk, .rst, .item(q_head), .item_valid(q_ne), .pop(b_pop),
    .idle(b_idle), .done, .entry_index, .table_full, .answer_bit,
    .routeless_count
  );
endmodule
`default_nettype wire

// File: sv/nrt_front.sv
// nrt_front: accepts commands and cleans the query name
// depends on nrt_pkg
`default_nettype none
module nrt_front #(
  parameter int NAME_BYTES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              can_take,
  input  wire logic [2:0]        cmd,
  input  wire logic [63:0]       dest_name,
  input  wire logic              peer_given,
  input  wire logic [2:0]        peer_link,
  input  wire logic [5:0]        entry_sel,
  output nrt_pkg::nrt_item_t     item,
  output logic                   item_valid
);
  import nrt_pkg::*;

  logic [63:0] clean;

  // keep bytes before the first zero inside the name window
  always_comb begin
    logic alive;
    alive = 1'b1;
    clean = '0;
    for (int k = 0; k < 8; k++) begin
      if (k >= NAME_BYTES || dest_name[8*k +: 8] == 8'd0) alive = 1'b0;
      if (alive) clean[8*k +: 8] = dest_name[8*k +: 8];
    end
  end

  // registered classified transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && can_take;
    end
    if (start && can_take) begin
      item.cmd        <= cmd;
      item.name       <= clean;
      item.peer_given <= peer_given;
      item.peer_link  <= peer_link;
      item.entry_sel  <= entry_sel;
    end
  end
endmodule
`default_nettype wire

// File: sv/nrt_fifo.sv
// nrt_fifo: two-entry queue between front and back
// depends on nrt_pkg
`default_nettype none
module nrt_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire nrt_pkg::nrt_item_t push_item,
  input  wire logic          pop,
  output nrt_pkg::nrt_item_t head,
  output logic               not_empty,
  output logic               has_room
);
  import nrt_pkg::*;

  nrt_item_t  slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign head      = slots[rptr];
  assign not_empty = count != 2'd0;
  assign has_room  = count == 2'd0;

  // pointer and occupancy update
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slots[wptr] <= push_item;
  end
endmodule
`default_nettype wire

// File: sv/nrt_back.sv
// nrt_back: executes commands against the table, scanning one entry at a time
// depends on nrt_pkg
`default_nettype none
module nrt_back #(
  parameter int TABLE_ENTRIES   = 64,
  parameter int PEER_LINKS      = 6,
  parameter int PERIPHERAL_LINK = 0,
  parameter int NAME_BYTES      = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire nrt_pkg::nrt_item_t item,
  input  wire logic          item_valid,
  output logic               pop,
  output logic               idle,
  output logic               done,
  output logic [5:0]         entry_index,
  output logic               table_full,
  output logic               answer_bit,
  output logic [6:0]         routeless_count
);
  import nrt_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [UW-1:0] LAST_FREE = UW'(TABLE_ENTRIES - 1);
  localparam logic [PEER_LINKS-1:0] PERIPH_BIT = (PERIPHERAL_LINK < PEER_LINKS) ?
                                                 PEER_LINKS'(1) << PERIPHERAL_LINK : '0;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_INVAL, S_FIN
  } state_t;

  state_t         state;
  logic [63:0]    names [TABLE_ENTRIES];
  // entries 0 and 1 live in up_routes and bc_routes, the rest in the memory
  logic [PEER_LINKS-1:0] routes [TABLE_ENTRIES];
  logic [PEER_LINKS-1:0] up_routes, bc_routes, rd_route;
  logic [UW-1:0]  used;
  logic           changed;
  logic [UW-1:0]  pos;
  logic [UW-1:0]  wpos;
  logic           inv_live;
  logic [63:0]    rd_name;
  logic [6:0]     cnt;
  nrt_item_t      cur;

  logic [PEER_LINKS-1:0] pb;
  logic [PEER_LINKS-1:0] pos_route, inv_route, inv_new, sel_route;
  logic [IW-1:0]  pos_i;
  logic [IW-1:0]  wpos_i;
  logic           match;
  assign pos_i  = pos[IW-1:0];
  assign wpos_i = wpos[IW-1:0];
  assign pb    = (32'(cur.peer_link) < PEER_LINKS) ?
                 PEER_LINKS'(1) << cur.peer_link : '0;
  assign pop   = (state == S_IDLE) && item_valid;
  assign idle  = (state == S_IDLE) && !item_valid;

  // route word of the entry at the scan, write-back and query positions
  assign pos_route = (pos == UW'(0)) ? up_routes :
                     (pos == UW'(1)) ? bc_routes : rd_route;
  assign inv_route = (wpos == UW'(0)) ? up_routes :
                     (wpos == UW'(1)) ? bc_routes : rd_route;
  assign inv_new   = inv_route & ~pb;
  assign sel_route = (cur.entry_sel == 6'd0) ? up_routes :
                     (cur.entry_sel == 6'd1) ? bc_routes : rd_route;

  // substring test of the current query against the read entry
  always_comb begin
    logic [3:0] lh, ln;
    logic ok;
    lh = 4'd0; ln = 4'd0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (rd_name[8*k +: 8] != 8'd0 && lh == 4'(k)) lh = 4'(k + 1);
      if (cur.name[8*k +: 8] != 8'd0 && ln == 4'(k)) ln = 4'(k + 1);
    end
    match = (ln == 4'd0);
    for (int s = 0; s < NAME_BYTES; s++) begin
      ok = (4'(s) + ln <= lh);
      for (int k = 0; k < NAME_BYTES; k++) begin
        if (4'(k) < ln && s + k < 8 && rd_name[8*(s+k) % 64 +: 8] != cur.name[8*k +: 8])
          ok = 1'b0;
      end
      if (ok) match = 1'b1;
    end
  end

  // sequencer, table and result registers
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      used      <= UW'(2);
      changed   <= 1'b1;
      inv_live  <= 1'b0;
      up_routes <= PERIPH_BIT;
      bc_routes <= PERIPH_BIT;
      names[0]  <= 64'd0;
      names[1]  <= 64'h2A;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur <= item;
            pos <= '0;
            cnt <= '0;
            inv_live <= 1'b0;
            rd_route <= routes[IW'(item.entry_sel)];
            entry_index <= '0; table_full <= 1'b0;
            answer_bit <= 1'b0; routeless_count <= '0;
            case (item.cmd)
              CMD_LOOKUP: state <= S_READ;
              CMD_INVAL:  state <= S_INVAL;
              default:    state <= S_FIN;
            endcase
          end
        end
        S_READ: begin
          if (pos < used) begin
            rd_name  <= names[pos_i];
            rd_route <= routes[pos_i];
            state <= S_SCAN;
          end else begin
            if (pos >= LAST_FREE) begin
              table_full <= 1'b1;
            end else begin
              names[pos_i]  <= cur.name;
              routes[pos_i] <= (cur.peer_given && pb != '0) ? pb : '0;
              used    <= used + UW'(1);
              changed <= 1'b1;
              entry_index <= 6'(pos);
              if (cur.peer_given && pb != '0) begin
                bc_routes <= bc_routes | pb;
                if (32'(cur.peer_link) == PERIPHERAL_LINK) up_routes <= up_routes | pb;
              end
            end
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (match) begin
            entry_index <= 6'(pos);
            if (cur.peer_given && pb != '0) begin
              if ((pos_route & pb) == '0) changed <= 1'b1;
              if (pos >= UW'(2)) routes[pos_i] <= pos_route | pb;
              bc_routes <= bc_routes | pb;
              if (pos == UW'(0) || 32'(cur.peer_link) == PERIPHERAL_LINK)
                up_routes <= up_routes | pb;
            end
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            pos <= pos + UW'(1);
            state <= S_READ;
          end
        end
        S_INVAL: begin
          // write back the entry read last cycle while reading the next one
          if (inv_live) begin
            if (wpos == UW'(0)) up_routes <= inv_new;
            else if (wpos == UW'(1)) bc_routes <= inv_new;
            else routes[wpos_i] <= inv_new;
            if (inv_new == '0) cnt <= cnt + 7'd1;
          end
          if (pos < used) begin
            rd_route <= routes[pos_i];
            wpos <= pos;
            inv_live <= 1'b1;
            pos <= pos + UW'(1);
          end else begin
            inv_live <= 1'b0;
            if (!inv_live) begin
              routeless_count <= cnt;
              changed <= 1'b1;
              done <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          case (cur.cmd)
            CMD_ROUTE:   answer_bit <= (UW'(cur.entry_sel) < used) &&
                           32'(cur.entry_sel) < TABLE_ENTRIES &&
                           (sel_route & pb) != '0;
            CMD_ANY:     answer_bit <= (UW'(cur.entry_sel) < used) &&
                           32'(cur.entry_sel) < TABLE_ENTRIES &&
                           sel_route != '0;
            CMD_CHANGED: begin
              answer_bit <= changed;
              changed <= 1'b0;
            end
            default: answer_bit <= 1'b0;
          endcase
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: tb/tb_name_route_table.sv
// tb_name_route_table: self-checking bench for the name route table
// depends on nrt_pkg and name_route_table; predicts each result from a local table copy
`default_nettype none
module tb_name_route_table;
  import nrt_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int PEER_LINKS = 6;
  localparam int PERIPHERAL_LINK = 0;
  localparam int UPSTREAM_ENTRY = 0;
  localparam int BROADCAST_ENTRY = 1;

  typedef struct packed {
    logic [5:0] idx;
    logic       full;
    logic       ans;
    logic [6:0] cnt;
  } route_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] cmd = '0;
  logic [63:0] dest_name = '0;
  logic peer_given = 1'b0;
  logic [2:0] peer_link = '0;
  logic [5:0] entry_sel = '0;
  logic busy, done, table_full, answer_bit;
  logic [5:0] entry_index;
  logic [6:0] routeless_count;

  name_route_table uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .dest_name(dest_name), .peer_given(peer_given), .peer_link(peer_link),
    .entry_sel(entry_sel), .done(done), .entry_index(entry_index),
    .table_full(table_full), .answer_bit(answer_bit),
    .routeless_count(routeless_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the route table
  logic [63:0] shadow_names [TABLE_ENTRIES];
  logic [PEER_LINKS-1:0] shadow_routes [TABLE_ENTRIES];
  int shadow_used;
  logic shadow_changed;

  nrt_item_t pending_cmds [$];
  route_result_t expected_results [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  bit hold_sender = 1'b0;

  function automatic int name_length(logic [63:0] n);
    int k;
    k = 0;
    while (k < 8 && n[8*k +: 8] != 8'h00) k++;
    return k;
  endfunction

  function automatic logic [63:0] trim_name(logic [63:0] n);
    int k;
    logic [63:0] m;
    k = name_length(n);
    m = '0;
    for (int i = 0; i < k; i++) m[8*i +: 8] = n[8*i +: 8];
    return m;
  endfunction

  function automatic bit holds_substring(logic [63:0] hay, logic [63:0] needle);
    int lh, ln;
    bit ok;
    lh = name_length(hay);
    ln = name_length(needle);
    if (ln == 0) return 1'b1;
    for (int s = 0; s + ln <= lh; s++) begin
      ok = 1'b1;
      for (int k = 0; k < ln; k++)
        if (hay[8*(s+k) +: 8] != needle[8*k +: 8]) ok = 1'b0;
      if (ok) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_names[i] = '0;
      shadow_routes[i] = '0;
    end
    shadow_names[BROADCAST_ENTRY] = 64'h2A;
    shadow_routes[UPSTREAM_ENTRY][PERIPHERAL_LINK] = 1'b1;
    shadow_routes[BROADCAST_ENTRY][PERIPHERAL_LINK] = 1'b1;
    shadow_used = 2;
    shadow_changed = 1'b1;
  endfunction

  // apply one command to the shadow table and return its result
  function automatic route_result_t route_apply(nrt_item_t it);
    route_result_t r;
    logic [63:0] q;
    logic [PEER_LINKS-1:0] pb;
    bit hit;
    int idx, cnt;
    r = '0;
    q = trim_name(it.name);
    pb = '0;
    if (it.peer_link < PEER_LINKS) pb[it.peer_link] = 1'b1;
    hit = 1'b0;
    idx = 0;
    cnt = 0;
    case (it.cmd)
      CMD_LOOKUP: begin
        for (int i = 0; i < shadow_used && !hit; i++)
          if (holds_substring(shadow_names[i], q)) begin
            idx = i;
            hit = 1'b1;
          end
        if (!hit) begin
          if (shadow_used + 1 >= TABLE_ENTRIES) begin
            r.full = 1'b1;
          end else begin
            idx = shadow_used;
            shadow_used++;
            shadow_names[idx] = q;
            shadow_routes[idx] = '0;
            shadow_changed = 1'b1;
            hit = 1'b1;
          end
        end
        if (hit && it.peer_given && pb != '0) begin
          if ((shadow_routes[idx] & pb) == '0) shadow_changed = 1'b1;
          shadow_routes[idx] |= pb;
          shadow_routes[BROADCAST_ENTRY] |= pb;
          if (it.peer_link == PERIPHERAL_LINK) shadow_routes[UPSTREAM_ENTRY] |= pb;
        end
        r.idx = idx[5:0];
      end
      CMD_INVAL: begin
        for (int i = 0; i < shadow_used; i++) begin
          shadow_routes[i] &= ~pb;
          if (shadow_routes[i] == '0) cnt++;
        end
        shadow_changed = 1'b1;
        r.cnt = cnt[6:0];
      end
      CMD_ROUTE: r.ans = (it.entry_sel < shadow_used) && ((shadow_routes[it.entry_sel] & pb) != '0);
      CMD_ANY: r.ans = (it.entry_sel < shadow_used) && (shadow_routes[it.entry_sel] != '0);
      CMD_CHANGED: begin
        r.ans = shadow_changed;
        shadow_changed = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // random name built from a small alphabet so substrings repeat
  function automatic logic [63:0] pick_name();
    logic [63:0] n;
    int len;
    n = '0;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++)
      n[8*i +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255))
                                                 : 8'($urandom_range(8'h61, 8'h64));
    if ($urandom_range(0, 7) == 0) n[63:56] = 8'($urandom);
    return n;
  endfunction

  function automatic nrt_item_t make_cmd(logic [2:0] c, logic [63:0] n, logic pg,
                                         logic [2:0] pl, logic [5:0] es);
    nrt_item_t it;
    it.cmd = c;
    it.name = n;
    it.peer_given = pg;
    it.peer_link = pl;
    it.entry_sel = es;
    return it;
  endfunction

  function automatic nrt_item_t random_cmd();
    int w;
    w = $urandom_range(0, 99);
    return make_cmd(w < 55 ? 3'(CMD_LOOKUP) : w < 62 ? 3'(CMD_INVAL) :
                    w < 77 ? 3'(CMD_ROUTE) : w < 90 ? 3'(CMD_ANY) :
                    w < 97 ? 3'(CMD_CHANGED) : 3'($urandom_range(5, 7)),
                    pick_name(), 1'($urandom), 3'($urandom_range(0, 7)), 6'($urandom));
  endfunction

  // driver: hands out pending commands, predicting at acceptance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) void'(pending_cmds.pop_front());
      if (start && !busy)
        expected_results.push_back(route_apply(make_cmd(cmd, dest_name, peer_given,
                                                         peer_link, entry_sel)));
      if (pending_cmds.size() > (start && !busy ? 1 : 0) && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        nrt_item_t nx;
        nx = pending_cmds[(start && !busy) ? 1 : 0];
        start <= 1'b1;
        cmd <= nx.cmd;
        dest_name <= nx.name;
        peer_given <= nx.peer_given;
        peer_link <= nx.peer_link;
        entry_sel <= nx.entry_sel;
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result idx=%0d", entry_index);
      end else begin
        route_result_t e;
        e = expected_results.pop_front();
        if (e.idx !== entry_index || e.full !== table_full || e.ans !== answer_bit ||
            e.cnt !== routeless_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d full=%0b ans=%0b cnt=%0d got %0d %0b %0b %0d",
                     e.idx, e.full, e.ans, e.cnt, entry_index, table_full,
                     answer_bit, routeless_count);
        end
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    table_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: empty query, broadcast, all ops, bad peer, range, unknown cmd
    pending_cmds.push_back(make_cmd(CMD_CHANGED, '0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CHANGED, '0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, '0, 1, 3, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 64'h2A, 1, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 64'h6463_6261, 1, 5, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 64'h6362, 1, 5, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, '1, 1, 7, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 64'hFF00_0000_0000_0061, 1, 6, 0));
    pending_cmds.push_back(make_cmd(CMD_ROUTE, '0, 0, 5, 2));
    pending_cmds.push_back(make_cmd(CMD_ROUTE, '0, 0, 7, 2));
    pending_cmds.push_back(make_cmd(CMD_ANY, '0, 0, 0, 3));
    pending_cmds.push_back(make_cmd(CMD_ANY, '0, 0, 0, 63));
    pending_cmds.push_back(make_cmd(CMD_INVAL, '0, 0, 7, 0));
    pending_cmds.push_back(make_cmd(CMD_INVAL, '0, 0, 5, 0));
    pending_cmds.push_back(make_cmd(3'd5, '1, 1, 7, 63));
    pending_cmds.push_back(make_cmd(3'd7, '1, 1, 7, 63));
    pending_cmds.push_back(make_cmd(CMD_CHANGED, '0, 0, 0, 0));
    drain();
    // everything is back; hold the sender off before the random phases
    hold_sender = 1'b1;
    repeat (50) @(posedge clk);
    hold_sender = 1'b0;
    // random phases; unique names fill the table to exercise full
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 60 : (ph == 2 ? 21 : 0);
      for (int i = 0; i < 440; i++) pending_cmds.push_back(random_cmd());
      drain();
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
